// ===== sv/swa_pkg.sv =====
// Shared types and constants of the saturating width ALU.
package swa_pkg;

   localparam int PORT_WIDTH         = 64;
   localparam int LIN_WIDTH          = PORT_WIDTH + 1;
   localparam int WIDTH_BITS         = 7;
   localparam int DATA_WIDTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic [2:0] {
      ACT_CLAMP = 3'd0,
      ACT_ADD   = 3'd1,
      ACT_SUB   = 3'd2,
      ACT_MUL   = 3'd3,
      ACT_DIV   = 3'd4,
      ACT_REM   = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_WIDTH   = 2'd1,
      ST_NEG_OPERAND = 2'd2,
      ST_DIV_ZERO    = 2'd3
   } status_type;

   typedef struct packed {
      action_type                   action;
      status_type                   status;
      logic                         a_neg;
      logic                         b_neg;
      logic                         is_signed;
      logic [WIDTH_BITS-1:0]        width_bits;
      logic [PORT_WIDTH-1:0]        mag_a;
      logic [PORT_WIDTH-1:0]        mag_b;
      logic signed [LIN_WIDTH-1:0]  lin;
   } item_type;

   typedef struct packed {
      logic [PORT_WIDTH-1:0] result_value;
      logic                  saturated;
      status_type            status;
   } result_type;

endpackage

// ===== sv/swa_queue.sv =====
// Small register queue used between the front, the back and the result port.
module swa_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = swa_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/swa_front.sv =====
// Front end: sign handling, magnitudes, add/subtract and error classification.
module swa_front #(
   parameter int DATA_WIDTH = swa_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic [2:0]                        action,
   input  logic [swa_pkg::PORT_WIDTH-1:0]    operand_a,
   input  logic [swa_pkg::PORT_WIDTH-1:0]    operand_b,
   input  logic [swa_pkg::WIDTH_BITS-1:0]    width_bits,
   input  logic                              is_signed,
   output swa_pkg::item_type                 item
);

   localparam int W = DATA_WIDTH;

   swa_pkg::action_type act;
   logic [W-1:0]        a_w, b_w, mag_a, mag_b;
   logic                a_neg, b_neg, arith, div_like, width_bad;
   logic signed [W:0]   a_x, b_x, lin_w;

   assign act      = swa_pkg::action_type'(action);
   assign a_w      = operand_a[W-1:0];
   assign b_w      = operand_b[W-1:0];
   assign a_neg    = a_w[W-1];
   assign b_neg    = b_w[W-1];
   assign mag_a    = a_neg ? (~a_w + 1'b1) : a_w;
   assign mag_b    = b_neg ? (~b_w + 1'b1) : b_w;
   assign a_x      = {a_w[W-1], a_w};
   assign b_x      = {b_w[W-1], b_w};
   assign arith    = (act == swa_pkg::ACT_ADD) || (act == swa_pkg::ACT_SUB) ||
                     (act == swa_pkg::ACT_MUL) || (act == swa_pkg::ACT_DIV) ||
                     (act == swa_pkg::ACT_REM);
   assign div_like = (act == swa_pkg::ACT_DIV) || (act == swa_pkg::ACT_REM);
   assign width_bad = (width_bits == '0) ||
                      (width_bits >= swa_pkg::WIDTH_BITS'(W));

   always_comb begin
      unique case (act)
         swa_pkg::ACT_ADD: lin_w = a_x + b_x;
         swa_pkg::ACT_SUB: lin_w = a_x - b_x;
         default:          lin_w = a_x;
      endcase
   end

   always_comb begin
      item            = '0;
      item.action     = act;
      item.a_neg      = a_neg;
      item.b_neg      = b_neg;
      item.is_signed  = is_signed;
      item.width_bits = width_bits;
      item.mag_a      = swa_pkg::PORT_WIDTH'(mag_a);
      item.mag_b      = swa_pkg::PORT_WIDTH'(mag_b);
      item.lin        = swa_pkg::LIN_WIDTH'(lin_w);
      priority if (arith && !is_signed && (a_neg || b_neg)) begin
         item.status = swa_pkg::ST_NEG_OPERAND;
      end else if (div_like && (b_w == '0)) begin
         item.status = swa_pkg::ST_DIV_ZERO;
      end else if (width_bad) begin
         item.status = swa_pkg::ST_BAD_WIDTH;
      end else begin
         item.status = swa_pkg::ST_OK;
      end
   end

endmodule

// ===== sv/swa_back.sv =====
// Back end: split multiplier, one-bit-per-stage divider, exact value and clamp.
module swa_back #(
   parameter int DATA_WIDTH = swa_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  swa_pkg::item_type    in_item,
   output logic                 in_take,
   input  logic                 out_room,
   output logic                 out_valid,
   output swa_pkg::result_type  out_result
);

   localparam int W  = DATA_WIDTH;
   localparam int H  = (W + 1) / 2;
   localparam int L  = W - H;
   localparam int W2 = 2 * W;

   typedef struct packed {
      swa_pkg::action_type action;
      swa_pkg::status_type status;
      logic                a_neg;
      logic                b_neg;
      logic                sgn;
      logic [swa_pkg::WIDTH_BITS-1:0] wb;
      logic signed [W:0]   lin;
      logic [W-1:0]        dvs;
      logic [W-1:0]        rem;
      logic [W-1:0]        quo;
      logic [2*H-1:0]      pp_ll;
      logic [W-1:0]        pp_lh;
      logic [W-1:0]        pp_hl;
      logic [2*L-1:0]      pp_hh;
      logic [W2-1:0]       prod;
   } stage_type;

   typedef struct packed {
      swa_pkg::status_type status;
      logic signed [W2-1:0] exact;
      logic signed [W-1:0]  hi;
      logic signed [W-1:0]  lo;
   } exact_type;

   stage_type st_in [W];
   stage_type st_ff [W];
   logic      valid_ff [W];
   stage_type init;
   exact_type ex_in, ex_ff;
   logic      ex_valid_ff;
   logic      adv;

   assign adv     = out_room;
   assign in_take = adv && in_valid;

   always_comb begin
      init        = '0;
      init.action = in_item.action;
      init.status = in_item.status;
      init.a_neg  = in_item.a_neg;
      init.b_neg  = in_item.b_neg;
      init.sgn    = in_item.is_signed;
      init.wb     = in_item.width_bits;
      init.lin    = in_item.lin[W:0];
      init.dvs    = in_item.mag_b[W-1:0];
      init.rem    = '0;
      init.quo    = in_item.mag_a[W-1:0];
      init.pp_ll  = in_item.mag_a[H-1:0] * in_item.mag_b[H-1:0];
      init.pp_lh  = W'(in_item.mag_a[H-1:0] * in_item.mag_b[W-1:H]);
      init.pp_hl  = W'(in_item.mag_a[W-1:H] * in_item.mag_b[H-1:0]);
      init.pp_hh  = in_item.mag_a[W-1:H] * in_item.mag_b[W-1:H];
   end

   for (genvar k = 0; k < W; k++) begin : g_stage
      always_comb begin
         stage_type     src;
         logic [W:0]    trial;
         logic [W:0]    diff;
         if (k == 0) begin
            src = init;
         end else begin
            src = st_ff[(k == 0) ? 0 : k - 1];
         end
         st_in[k] = src;
         trial    = {src.rem, src.quo[W-1]};
         diff     = trial - {1'b0, src.dvs};
         if (!diff[W]) begin
            st_in[k].rem = diff[W-1:0];
            st_in[k].quo = {src.quo[W-2:0], 1'b1};
         end else begin
            st_in[k].rem = trial[W-1:0];
            st_in[k].quo = {src.quo[W-2:0], 1'b0};
         end
         if (k == 1) begin
            st_in[k].prod = W2'(src.pp_ll) +
                            ((W2'(src.pp_lh) + W2'(src.pp_hl)) << H) +
                            (W2'(src.pp_hh) << (2 * H));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= (k == 0) ? in_take : valid_ff[(k == 0) ? 0 : k - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      stage_type           s;
      logic [W-1:0]        one_w;
      logic signed [W2-1:0] qv, rv, pv;
      s            = st_ff[W-1];
      one_w        = W'(1);
      qv           = signed'(W2'(s.quo));
      rv           = signed'(W2'(s.rem));
      pv           = signed'(s.prod);
      ex_in        = '0;
      ex_in.status = s.status;
      unique case (s.action)
         swa_pkg::ACT_MUL: ex_in.exact = (s.a_neg != s.b_neg) ? -pv : pv;
         swa_pkg::ACT_DIV: ex_in.exact = (s.a_neg != s.b_neg) ? -qv : qv;
         swa_pkg::ACT_REM: ex_in.exact = s.a_neg ? -rv : rv;
         default:          ex_in.exact = {{(W - 1){s.lin[W]}}, s.lin};
      endcase
      if (s.sgn) begin
         ex_in.hi = signed'((one_w << (s.wb - 1'b1)) - 1'b1);
         ex_in.lo = signed'(~(one_w << (s.wb - 1'b1)) + 1'b1);
      end else begin
         ex_in.hi = signed'((one_w << s.wb) - 1'b1);
         ex_in.lo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else if (adv) begin
         ex_valid_ff <= valid_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ex_ff <= ex_in;
      end
   end

   always_comb begin
      logic signed [W2-1:0] hi_x, lo_x;
      logic signed [W-1:0]  v;
      logic                 sat;
      hi_x = {{W{ex_ff.hi[W-1]}}, ex_ff.hi};
      lo_x = {{W{ex_ff.lo[W-1]}}, ex_ff.lo};
      priority if (ex_ff.exact > hi_x) begin
         v   = ex_ff.hi;
         sat = 1'b1;
      end else if (ex_ff.exact < lo_x) begin
         v   = ex_ff.lo;
         sat = 1'b1;
      end else begin
         v   = ex_ff.exact[W-1:0];
         sat = 1'b0;
      end
      out_result.status = ex_ff.status;
      if (ex_ff.status == swa_pkg::ST_OK) begin
         out_result.result_value = swa_pkg::PORT_WIDTH'(v);
         out_result.saturated    = sat;
      end else begin
         out_result.result_value = '0;
         out_result.saturated    = 1'b0;
      end
   end

   assign out_valid = adv && ex_valid_ff;

endmodule

// ===== sv/saturating_width_alu.sv =====
// Top level of the saturating width ALU: front, request queue, back, result queue.
// Path: a request accepted into the request queue passes the DATA_WIDTH divider stages,
// the exact-value register and the result queue.
// Throughput: one request per cycle while the result queue has room; every request runs the
// divider pipeline of DATA_WIDTH stages, one quotient bit per stage, beside the two-stage split multiplier.
// Reset empties both queues and clears every pipeline valid bit.
module saturating_width_alu #(
   parameter int DATA_WIDTH = swa_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [2:0]                        req_action,
   input  logic [swa_pkg::PORT_WIDTH-1:0]    req_operand_a,
   input  logic [swa_pkg::PORT_WIDTH-1:0]    req_operand_b,
   input  logic [swa_pkg::WIDTH_BITS-1:0]    req_width_bits,
   input  logic                              req_is_signed,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [swa_pkg::PORT_WIDTH-1:0]    rsp_result_value,
   output logic                              rsp_saturated,
   output logic [1:0]                        rsp_status
);

   localparam int ITEM_BITS   = $bits(swa_pkg::item_type);
   localparam int RESULT_BITS = $bits(swa_pkg::result_type);

   swa_pkg::item_type   front_item;
   logic [ITEM_BITS-1:0] mid_data;
   logic                mid_empty, mid_take;
   swa_pkg::result_type back_result;
   logic                back_valid, out_full;
   logic [RESULT_BITS-1:0] out_data;
   swa_pkg::result_type rsp_item;

   swa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .action     (req_action),
      .operand_a  (req_operand_a),
      .operand_b  (req_operand_b),
      .width_bits (req_width_bits),
      .is_signed  (req_is_signed),
      .item       (front_item)
   );

   swa_queue #(.WIDTH(ITEM_BITS), .DEPTH(swa_pkg::QUEUE_DEPTH)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (ITEM_BITS'(front_item)),
      .full      (req_full),
      .pop       (mid_take),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   swa_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (!mid_empty),
      .in_item    (swa_pkg::item_type'(mid_data)),
      .in_take    (mid_take),
      .out_room   (!out_full),
      .out_valid  (back_valid),
      .out_result (back_result)
   );

   swa_queue #(.WIDTH(RESULT_BITS), .DEPTH(swa_pkg::QUEUE_DEPTH)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (RESULT_BITS'(back_result)),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_data),
      .empty     (rsp_empty)
   );

   assign rsp_item         = swa_pkg::result_type'(out_data);
   assign rsp_result_value = rsp_item.result_value;
   assign rsp_saturated    = rsp_item.saturated;
   assign rsp_status       = rsp_item.status;

endmodule

// ===== verif/tb_saturating_width_alu.sv =====
// Testbench of the saturating width ALU: random and corner requests checked by a scoreboard.
module tb_saturating_width_alu;

   class alu_scoreboard;
      logic [63:0] want_value[$];
      logic        want_sat[$];
      logic [1:0]  want_status[$];
      int          mismatches;

      function void note_request(logic [2:0] act, logic [63:0] a, logic [63:0] b,
                                 logic [6:0] w, logic sgn);
         logic signed [129:0] exact;
         logic signed [129:0] lo_bound;
         logic signed [129:0] hi_bound;
         logic signed [129:0] sa;
         logic signed [129:0] sb;
         logic [63:0]         ma;
         logic [63:0]         mb;
         logic [1:0]          st;
         logic [63:0]         val;
         logic                sat;
         logic                a_neg;
         logic                b_neg;
         a_neg = a[63];
         b_neg = b[63];
         sa = $signed({{66{a[63]}}, a});
         sb = $signed({{66{b[63]}}, b});
         ma = a_neg ? -a : a;
         mb = b_neg ? -b : b;
         st = swa_pkg::ST_OK;
         val = '0;
         sat = 1'b0;
         if (act >= swa_pkg::ACT_ADD && act <= swa_pkg::ACT_REM && !sgn && (a_neg || b_neg))
            st = swa_pkg::ST_NEG_OPERAND;
         else if ((act == swa_pkg::ACT_DIV || act == swa_pkg::ACT_REM) && b == 0)
            st = swa_pkg::ST_DIV_ZERO;
         else if (w == 0 || w >= 64)
            st = swa_pkg::ST_BAD_WIDTH;
         if (st == swa_pkg::ST_OK) begin
            case (act)
               swa_pkg::ACT_ADD: exact = sa + sb;
               swa_pkg::ACT_SUB: exact = sa - sb;
               swa_pkg::ACT_MUL: exact = sa * sb;
               swa_pkg::ACT_DIV: begin
                  exact = $signed({66'd0, ma / mb});
                  if (a_neg != b_neg) exact = -exact;
               end
               swa_pkg::ACT_REM: begin
                  exact = $signed({66'd0, ma % mb});
                  if (a_neg) exact = -exact;
               end
               default: exact = sa;
            endcase
            if (sgn) begin
               lo_bound = -($signed(130'd1) <<< (w - 1));
               hi_bound = ($signed(130'd1) <<< (w - 1)) - 1;
            end else begin
               lo_bound = 0;
               hi_bound = ($signed(130'd1) <<< w) - 1;
            end
            if (exact > hi_bound) begin
               val = hi_bound[63:0];
               sat = 1'b1;
            end else if (exact < lo_bound) begin
               val = lo_bound[63:0];
               sat = 1'b1;
            end else begin
               val = exact[63:0];
            end
         end
         want_value.push_back(val);
         want_sat.push_back(sat);
         want_status.push_back(st);
      endfunction

      function void check_result(logic [63:0] val, logic sat, logic [1:0] st);
         logic [63:0] ev;
         logic        es;
         logic [1:0]  et;
         if (want_value.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result value=%h sat=%b status=%0d", val, sat, st);
            return;
         end
         ev = want_value.pop_front();
         es = want_sat.pop_front();
         et = want_status.pop_front();
         if (val !== ev || sat !== es || st !== et) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected value=%h sat=%b status=%0d, %s",
                        ev, es, et,
                        $sformatf("got value=%h sat=%b status=%0d", val, sat, st));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [2:0]  req_action = '0;
   logic [63:0] req_operand_a = '0;
   logic [63:0] req_operand_b = '0;
   logic [6:0]  req_width_bits = '0;
   logic        req_is_signed = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [63:0] rsp_result_value;
   logic        rsp_saturated;
   logic [1:0]  rsp_status;

   int          send_idle_pct;
   int          recv_idle_pct;
   alu_scoreboard board;

   localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_VAL = 64'h7fff_ffff_ffff_ffff;

   saturating_width_alu uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function logic [63:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return MIN_VAL;
         1: return MAX_VAL;
         2: return {$urandom, $urandom};
         3: return 64'($signed($urandom_range(0, 40)) - 20);
         4: return {{33{$urandom_range(0, 1) == 1}}, 31'($urandom)};
         5: return 64'(1) << $urandom_range(0, 63);
         default: return {{48{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      endcase
   endfunction

   task automatic send_request(logic [2:0] act, logic [63:0] a, logic [63:0] b,
                               logic [6:0] w, logic sgn);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push       <= 1'b1;
      req_action     <= act;
      req_operand_a  <= a;
      req_operand_b  <= b;
      req_width_bits <= w;
      req_is_signed  <= sgn;
      do @(posedge clock); while (req_full);
      board.note_request(act, a, b, w, sgn);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [6:0] w;
      w = ($urandom_range(0, 19) == 0) ? 7'($urandom) : 7'($urandom_range(1, 63));
      send_request(3'($urandom_range(0, 7)), pick_operand(), pick_operand(), w,
                   $urandom_range(0, 3) != 0);
   endtask

   always @(negedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         board.check_result(rsp_result_value, rsp_saturated, rsp_status);
   end

   initial begin
      #4000000;
      $display("tb_saturating_width_alu: errors");
      $finish;
   end

   initial begin
      int wait_cycles;
      board = new();
      send_idle_pct = 11;
      recv_idle_pct = 68;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int act = 0; act < 8; act++) begin
         send_request(3'(act), MIN_VAL, 64'hffff_ffff_ffff_ffff, 7'd63, 1'b1);
         send_request(3'(act), MAX_VAL, MAX_VAL, 7'd1, 1'b0);
      end
      send_request(swa_pkg::ACT_DIV, 64'd7, 64'd0, 7'd8, 1'b1);
      send_request(swa_pkg::ACT_REM, 64'd7, 64'd0, 7'd8, 1'b0);
      send_request(swa_pkg::ACT_ADD, 64'hffff_ffff_ffff_fff9, 64'd0, 7'd0, 1'b0);
      send_request(swa_pkg::ACT_CLAMP, 64'hffff_ffff_ffff_fff9, 64'd0, 7'd5, 1'b0);
      send_request(swa_pkg::ACT_ADD, 64'd3, 64'd4, 7'd64, 1'b1);
      send_request(swa_pkg::ACT_SUB, 64'd3, 64'd4, 7'd127, 1'b0);
      send_request(swa_pkg::ACT_MUL, MIN_VAL, MIN_VAL, 7'd63, 1'b0);
      send_request(swa_pkg::ACT_REM, 64'hffff_ffff_ffff_fff9, 64'd2, 7'd4, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 68;
            recv_idle_pct = 11;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (600) send_random();
      end
      req_push <= 1'b0;

      wait_cycles = 0;
      while (board.want_value.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (80) @(posedge clock);
      if (board.mismatches == 0 && board.want_value.size() == 0)
         $display("tb_saturating_width_alu: clean");
      else
         $display("tb_saturating_width_alu: errors");
      $finish;
   end
endmodule

// ===== saturating_width_alu.f =====
sv/swa_pkg.sv
sv/swa_queue.sv
sv/swa_front.sv
sv/swa_back.sv
sv/saturating_width_alu.sv
verif/tb_saturating_width_alu.sv
